/* design/annexb_pkg.sv */
// ----------------------------------------------------------------------------
// annexb_pkg
// shared constants for the annex b nal unit splitter
// ----------------------------------------------------------------------------
package annexb_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W = 8;
    localparam int WIN_W  = 32;
    localparam int TYPE_W = 6;
    localparam int SIZE_W = 32;
    localparam int CLEN_W = 3;
    localparam int PRIM_W = 2;
    localparam int HDR_W  = 3;

    localparam logic [WIN_W-1:0]  WIN_MARK_BIT = 32'h0100_0000;
    localparam logic [WIN_W-1:0]  FOUR_CODE    = 32'h0000_0001;
    localparam logic [23:0]       THREE_CODE   = 24'h00_0001;
    localparam logic [HDR_W-1:0]  HEADER_BYTES = 3'd4;
    localparam logic [PRIM_W-1:0] PRIME_BYTES  = 2'd3;
    localparam logic [CLEN_W-1:0] CODE_LEN_3   = 3'd3;
    localparam logic [CLEN_W-1:0] CODE_LEN_4   = 3'd4;

endpackage

/* design/annexb_nal_unit_splitter.sv */
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// scans an h.265 annex b byte stream for start codes and reports each nal unit
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | stream_byte, final_byte
//   out     | output    | out_valid / out_ready| nal_kind, nal_length,
//           |           |                      | nalu_position, start_code_length
//
// one byte per clock while in_ready is high; each beat is scanned in the cycle
// it is accepted and a unit report appears in the output register on the next cycle.
// in_ready drops only while a report waits and out_ready is low.
// rst_n clears the scanner and the output valid flag; no clearing pass.
// after the final byte the scanner returns to its reset state.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
    import annexb_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   stream_byte,
    input  logic                final_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TYPE_W-1:0]   nal_kind,
    output logic [SIZE_W-1:0]   nal_length,
    output logic [SIZE_W-1:0]   nalu_position,
    output logic [CLEN_W-1:0]   start_code_length
);

    localparam int EXT_W = (POSITION_BITS > SIZE_W) ? POSITION_BITS : SIZE_W;

    logic [WIN_W-1:0]         window_reg, window_next;
    logic [POSITION_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [PRIM_W-1:0]        priming_reg, priming_next;
    logic [HDR_W-1:0]         header_reg, header_next;
    logic [POSITION_BITS-1:0] unit_start_reg, unit_start_next;
    logic [CLEN_W-1:0]        unit_clen_reg, unit_clen_next;
    logic [TYPE_W-1:0]        unit_type_reg, unit_type_next;
    logic                     unit_open_reg, unit_open_next;

    logic                     out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]        type_reg, type_next;
    logic [SIZE_W-1:0]        size_reg, size_next;
    logic [SIZE_W-1:0]        pos_reg, pos_next;
    logic [CLEN_W-1:0]        clen_reg, clen_next;

    logic                     accept;
    logic                     may_search;
    logic                     produce;
    logic [WIN_W-1:0]         shifted;
    logic [CLEN_W-1:0]        code_len;
    logic [POSITION_BITS-1:0] here;
    logic [POSITION_BITS-1:0] end_at;
    logic [EXT_W-1:0]         unit_len;
    logic [TYPE_W-1:0]        report_type;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign shifted  = {window_reg[WIN_W-BYTE_W-1:0], stream_byte};

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        window_next     = window_reg;
        priming_next    = priming_reg;
        header_next     = header_reg;
        unit_start_next = unit_start_reg;
        unit_clen_next  = unit_clen_reg;
        unit_type_next  = unit_type_reg;
        unit_open_next  = unit_open_reg;
        report_type     = unit_type_reg;
        may_search      = 1'b0;
        produce         = 1'b0;
        code_len        = '0;
        here            = '0;
        end_at          = '0;

        if (bytes_seen_reg != '1)
        begin
            bytes_seen_next = bytes_seen_reg + 1'b1;
        end

        // window update: priming, header skip or plain scan
        if (priming_reg < PRIME_BYTES)
        begin
            window_next  = shifted;
            priming_next = priming_reg + 1'b1;
            if (priming_reg == PRIME_BYTES - 1'b1)
            begin
                window_next = shifted | WIN_MARK_BIT;
                may_search  = 1'b1;
            end
        end
        else if (header_reg != '0)
        begin
            if (header_reg == HEADER_BYTES)
            begin
                unit_type_next = stream_byte[TYPE_W:1];
                report_type    = stream_byte[TYPE_W:1];
            end
            window_next = shifted;
            header_next = header_reg - 1'b1;
            if (header_reg == 3'd1)
            begin
                window_next = WIN_MARK_BIT | {8'h00, shifted[23:0]};
                may_search  = 1'b1;
            end
        end
        else
        begin
            window_next = shifted;
            may_search  = 1'b1;
        end

        if (window_next == FOUR_CODE)
        begin
            code_len = CODE_LEN_4;
        end
        else if (window_next[23:0] == THREE_CODE)
        begin
            code_len = CODE_LEN_3;
        end
        here = bytes_seen_next - POSITION_BITS'(code_len);

        if (final_byte)
        begin
            produce         = unit_open_reg;
            end_at          = bytes_seen_next;
            bytes_seen_next = '0;
            window_next     = '0;
            priming_next    = '0;
            header_next     = '0;
            unit_start_next = '0;
            unit_clen_next  = '0;
            unit_type_next  = '0;
            unit_open_next  = 1'b0;
        end
        else if (may_search && (code_len != '0))
        begin
            produce         = unit_open_reg;
            end_at          = here;
            unit_start_next = here;
            unit_clen_next  = code_len;
            unit_open_next  = 1'b1;
            header_next     = HEADER_BYTES;
        end

        unit_len = EXT_W'(end_at) - EXT_W'(unit_start_reg) - EXT_W'(unit_clen_reg);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        type_next      = type_reg;
        size_next      = size_reg;
        pos_next       = pos_reg;
        clen_next      = clen_reg;
        if (accept && produce)
        begin
            out_valid_next = 1'b1;
            type_next      = report_type;
            size_next      = unit_len[SIZE_W-1:0];
            pos_next       = SIZE_W'(EXT_W'(unit_start_reg));
            clen_next      = unit_clen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            bytes_seen_reg <= '0;
            priming_reg    <= '0;
            header_reg     <= '0;
            unit_start_reg <= '0;
            unit_clen_reg  <= '0;
            unit_type_reg  <= '0;
            unit_open_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                window_reg     <= window_next;
                bytes_seen_reg <= bytes_seen_next;
                priming_reg    <= priming_next;
                header_reg     <= header_next;
                unit_start_reg <= unit_start_next;
                unit_clen_reg  <= unit_clen_next;
                unit_type_reg  <= unit_type_next;
                unit_open_reg  <= unit_open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        size_reg <= size_next;
        pos_reg  <= pos_next;
        clen_reg <= clen_next;
    end

    assign out_valid         = out_valid_reg;
    assign nal_kind          = type_reg;
    assign nal_length        = size_reg;
    assign nalu_position     = pos_reg;
    assign start_code_length = clen_reg;

    // header skip only after priming and only inside an open unit
    a_header_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (header_reg != '0) |-> (priming_reg == PRIME_BYTES) && unit_open_reg)
        else $error("header skip outside an open unit");

    a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_reg <= HEADER_BYTES)
        else $error("header count out of range");

    a_open_code_len: assert property (@(posedge clk) disable iff (!rst_n)
        unit_open_reg |-> (unit_clen_reg == CODE_LEN_3) || (unit_clen_reg == CODE_LEN_4))
        else $error("open unit without a valid start code length");

    a_report_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && unit_open_reg))
        else $error("report without an accepted beat on an open unit");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the annex b nal unit splitter: byte streams with
// 3- and 4-byte start codes, truncated and noisy streams, checked per field
// against a scanner model kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
    import annexb_pkg::*;

    localparam int          POS_BITS       = POSITION_BITS_DEF;
    localparam logic [63:0] COUNT_MAX      = (64'd1 << POS_BITS) - 64'd1;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [TYPE_W-1:0] nal_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [SIZE_W-1:0] position;
        logic [CLEN_W-1:0] code_len;
    } nal_report_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   stream_byte;
    logic                final_byte;
    logic                out_valid;
    logic                out_ready;
    logic [TYPE_W-1:0]   nal_kind;
    logic [SIZE_W-1:0]   nal_length;
    logic [SIZE_W-1:0]   nalu_position;
    logic [CLEN_W-1:0]   start_code_length;

    // scanner model state
    logic [WIN_W-1:0]    scan_window;
    logic [63:0]         byte_count;
    logic [PRIM_W-1:0]   prime_cnt;
    logic [HDR_W-1:0]    hdr_left;
    logic [63:0]         open_start;
    logic [CLEN_W-1:0]   open_clen;
    logic [TYPE_W-1:0]   open_type;
    logic                open_flag;

    nal_report_t         pending_reports[$];
    nal_report_t         got_report;
    nal_report_t         want_report;
    logic [BYTE_W-1:0]   stream_bytes[$];
    int                  fail_count = 0;
    int                  bytes_sent;
    int                  idle_cycles = 0;
    bit                  idle_en;

    annexb_nal_unit_splitter uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .stream_byte       (stream_byte),
        .final_byte        (final_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .nal_kind          (nal_kind),
        .nal_length        (nal_length),
        .nalu_position     (nalu_position),
        .start_code_length (start_code_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_scanner();
        scan_window = '0;
        byte_count  = '0;
        prime_cnt   = '0;
        hdr_left    = '0;
        open_start  = '0;
        open_clen   = '0;
        open_type   = '0;
        open_flag   = 1'b0;
    endtask

    task automatic push_report(input logic [63:0] end_at);
        nal_report_t r;
        logic [63:0] len;
        len          = end_at - open_start - 64'(open_clen);
        r.nal_type   = open_type;
        r.size_bytes = len[SIZE_W-1:0];
        r.position   = open_start[SIZE_W-1:0];
        r.code_len   = open_clen;
        pending_reports.push_back(r);
    endtask

    task automatic scan_stream_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic              search;
        logic [CLEN_W-1:0] clen;
        logic [63:0]       here;
        search = 1'b0;
        clen   = '0;
        if (byte_count < COUNT_MAX)
            byte_count++;
        if (prime_cnt < PRIME_BYTES)
        begin
            scan_window = {scan_window[23:0], b};
            prime_cnt++;
            if (prime_cnt == PRIME_BYTES)
            begin
                scan_window = scan_window | WIN_MARK_BIT;
                search      = 1'b1;
            end
        end
        else if (hdr_left != 0)
        begin
            if (hdr_left == HEADER_BYTES)
                open_type = b[6:1];
            scan_window = {scan_window[23:0], b};
            hdr_left--;
            if (hdr_left == 0)
            begin
                scan_window = WIN_MARK_BIT | {8'h00, scan_window[23:0]};
                search      = 1'b1;
            end
        end
        else
        begin
            scan_window = {scan_window[23:0], b};
            search      = 1'b1;
        end

        if (last)
        begin
            if (open_flag)
                push_report(byte_count);
            clear_scanner();
        end
        else if (search)
        begin
            if (scan_window == FOUR_CODE)
                clen = CODE_LEN_4;
            else if (scan_window[23:0] == THREE_CODE)
                clen = CODE_LEN_3;
            if (clen != 0)
            begin
                here = byte_count - 64'(clen);
                if (open_flag)
                    push_report(here);
                open_start = here;
                open_clen  = clen;
                open_flag  = 1'b1;
                hdr_left   = HEADER_BYTES;
            end
        end
    endtask

    // model advances on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            scan_stream_byte(stream_byte, final_byte);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_report = '{nal_kind, nal_length, nalu_position, start_code_length};
            if (pending_reports.size() == 0)
            begin
                $error("report with none expected: type %0d size %0d pos %0d len %0d",
                       nal_kind, nal_length, nalu_position, start_code_length);
                fail_count++;
            end
            else
            begin
                want_report = pending_reports.pop_front();
                if (got_report.nal_type !== want_report.nal_type)
                begin
                    $error("nal_kind expected %0d got %0d",
                           want_report.nal_type, got_report.nal_type);
                    fail_count++;
                end
                if (got_report.size_bytes !== want_report.size_bytes)
                begin
                    $error("nal_length expected %0d got %0d",
                           want_report.size_bytes, got_report.size_bytes);
                    fail_count++;
                end
                if (got_report.position !== want_report.position)
                begin
                    $error("nalu_position expected %0d got %0d",
                           want_report.position, got_report.position);
                    fail_count++;
                end
                if (got_report.code_len !== want_report.code_len)
                begin
                    $error("start_code_length expected %0d got %0d",
                           want_report.code_len, got_report.code_len);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (idle_en)
            out_ready <= ($urandom_range(99) >= 10);
        else
            out_ready <= 1'b1;
    end

    // stuck detection: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        @(negedge clk);
        if (idle_en && $urandom_range(99) < 4)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4) + 1) @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        final_byte  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic bus_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        bus_idle();
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_stream();
        int n;
        n = stream_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(stream_bytes[i], i == n - 1);
        stream_bytes.delete();
    endtask

    function automatic logic [BYTE_W-1:0] payload_byte(input int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return 8'h00;
        else if (r < zero_pct + 4)
            return 8'h01;
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic build_coded_stream(input int units);
        int plen;
        int cut;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(5)) stream_bytes.push_back(payload_byte(10));
        for (int k = 0; k < units; k++)
        begin
            if ($urandom_range(1) == 1)
                stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h01);
            stream_bytes.push_back(8'($urandom_range(255)));
            plen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(12);
            repeat (plen) stream_bytes.push_back(payload_byte(10));
        end
        // broken tail: cut the stream short anywhere
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(stream_bytes.size() - 1);
            while (stream_bytes.size() > cut + 1)
                void'(stream_bytes.pop_back());
        end
    endtask

    task automatic test_directed();
        // 4-byte code in priming, 3-byte code after header, ends inside header
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7e, 8'h01, 8'h00, 8'h00,
                         8'h01, 8'hff, 8'h80, 8'hff};
        send_stream();
        // 4-byte code after a zero run, type zero, cut in header
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_stream();
        // single-byte stream, no unit
        stream_bytes = '{8'hab};
        send_stream();
        // start code on the final byte is not searched
        stream_bytes = '{8'h00, 8'h00, 8'h01};
        send_stream();
    endtask

    task automatic test_coded_streams(input int upto);
        while (bytes_sent < upto)
        begin
            build_coded_stream($urandom_range(6) + 1);
            send_stream();
        end
    endtask

    task automatic test_drain_pause();
        build_coded_stream(3);
        send_stream();
        wait_drained();
        build_coded_stream(2);
        send_stream();
    endtask

    task automatic test_noise_streams(input int upto);
        int len;
        while (bytes_sent < upto)
        begin
            len = $urandom_range(40) + 1;
            repeat (len) stream_bytes.push_back(payload_byte(30));
            send_stream();
        end
    endtask

    task automatic test_no_idle(input int upto);
        idle_en = 1'b0;
        test_coded_streams(upto);
        idle_en = 1'b1;
    endtask

    initial
    begin
        clear_scanner();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        stream_byte = '0;
        final_byte  = 1'b0;
        bytes_sent  = 0;
        idle_en     = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_coded_streams(1200);
        test_drain_pause();
        test_noise_streams(1550);
        test_no_idle(1950);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
